@@ hdl/four_digit_seven_segment_encoder_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the four digit seven segment encoder
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef FOUR_DIGIT_SEVEN_SEGMENT_ENCODER_DEFINES_SVH
`define FOUR_DIGIT_SEVEN_SEGMENT_ENCODER_DEFINES_SVH
`ifndef SYNTHESIS
// ante implies cons in the same cycle
`define FDSE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("fdse assertion failed");
// ante implies cons in the following cycle
`define FDSE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("fdse assertion failed");
`else
`define FDSE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define FDSE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ hdl/fdse_pkg.sv @@
// ---------------------------------------------------------------------------
// fdse_pkg
// Types, constants and lookup functions shared by the encoder modules.
// ---------------------------------------------------------------------------
`default_nettype none

package fdse_pkg;

  localparam int DigitCount = 4;
  localparam int PosW       = $clog2(DigitCount);
  localparam int ValueW     = 16;
  localparam int PointW     = 4;
  localparam int SegW       = 8;
  localparam int SelW       = 8;
  localparam int BaseW      = 5;
  localparam int DigW       = 4;
  localparam int W1W        = 5;
  localparam int W2W        = 9;
  localparam int W3W        = 13;
  localparam int RemW       = 12;
  localparam int TopQW      = 13;
  localparam int HiSteps    = 7;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 5;
  localparam int QDepth     = 2;
  localparam int QPtrW      = $clog2(QDepth);
  localparam int QCntW      = $clog2(QDepth + 1);

  localparam logic [PosW-1:0] PosFirst = PosW'(DigitCount - 1);
  localparam logic [PosW-1:0] PosLast  = '0;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDigitBase = 2'd0,
    CfgZeroFill  = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [PointW-1:0] point_mask;
  } item_t;

  typedef struct packed {
    logic [SegW-1:0] segments;
    logic [SelW-1:0] digit_select;
    logic            last;
  } result_t;

  // powers of the radix: weights of digit positions 1, 2 and 3
  typedef struct packed {
    logic [W1W-1:0] w1;
    logic [W2W-1:0] w2;
    logic [W3W-1:0] w3;
  } radix_t;

  typedef struct packed {
    logic              top_ovf;
    logic [DigW-1:0]   top_digit;
    logic [RemW-1:0]   rem;
    logic [2:0]        shown;
    logic [PointW-1:0] points;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam radix_t RadixReset = '{w1: 5'd10, w2: 9'd100, w3: 13'd1000};

  function automatic logic [BaseW-1:0] clamp_base(input logic [BaseW-1:0] raw);
    logic [BaseW-1:0] b;
    b = raw;
    if (raw < BaseW'(2)) b = BaseW'(2);
    if (raw > BaseW'(16)) b = BaseW'(16);
    return b;
  endfunction

  function automatic radix_t radix_of(input logic [BaseW-1:0] b);
    radix_t r;
    r.w1 = W1W'(b);
    case (b)
      5'd2:    begin r.w2 = 9'd4;   r.w3 = 13'd8;    end
      5'd3:    begin r.w2 = 9'd9;   r.w3 = 13'd27;   end
      5'd4:    begin r.w2 = 9'd16;  r.w3 = 13'd64;   end
      5'd5:    begin r.w2 = 9'd25;  r.w3 = 13'd125;  end
      5'd6:    begin r.w2 = 9'd36;  r.w3 = 13'd216;  end
      5'd7:    begin r.w2 = 9'd49;  r.w3 = 13'd343;  end
      5'd8:    begin r.w2 = 9'd64;  r.w3 = 13'd512;  end
      5'd9:    begin r.w2 = 9'd81;  r.w3 = 13'd729;  end
      5'd10:   begin r.w2 = 9'd100; r.w3 = 13'd1000; end
      5'd11:   begin r.w2 = 9'd121; r.w3 = 13'd1331; end
      5'd12:   begin r.w2 = 9'd144; r.w3 = 13'd1728; end
      5'd13:   begin r.w2 = 9'd169; r.w3 = 13'd2197; end
      5'd14:   begin r.w2 = 9'd196; r.w3 = 13'd2744; end
      5'd15:   begin r.w2 = 9'd225; r.w3 = 13'd3375; end
      default: begin r.w1 = 5'd16;  r.w2 = 9'd256;  r.w3 = 13'd4096; end
    endcase
    return r;
  endfunction

  function automatic logic [SegW-1:0] glyph_of(input logic [DigW-1:0] d);
    logic [SegW-1:0] g;
    case (d)
      4'h0:    g = 8'hFC;
      4'h1:    g = 8'h60;
      4'h2:    g = 8'hDA;
      4'h3:    g = 8'hF2;
      4'h4:    g = 8'h66;
      4'h5:    g = 8'hB6;
      4'h6:    g = 8'hBE;
      4'h7:    g = 8'hE0;
      4'h8:    g = 8'hFE;
      4'h9:    g = 8'hF6;
      4'hA:    g = 8'hEE;
      4'hB:    g = 8'h3E;
      4'hC:    g = 8'h9C;
      4'hD:    g = 8'h7A;
      4'hE:    g = 8'h9E;
      default: g = 8'h8E;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

@@ hdl/fdse_front.sv @@
// ---------------------------------------------------------------------------
// fdse_front
// Accepts values, splits off the top digit by restoring division across the
// input register and classifies which leading positions are shown.
// ---------------------------------------------------------------------------
`default_nettype none

module fdse_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire fdse_pkg::item_t   item_i,
  input  wire fdse_pkg::radix_t  radix_i,
  input  wire fdse_pkg::q_stat_t q_stat_i,
  output logic                   push_o,
  output fdse_pkg::q_entry_t     entry_o
);
  import fdse_pkg::*;

  logic                  fv_q, fv_d;
  logic [ValueW-1:0]     v_q;
  logic [PointW-1:0]     pts_q;
  logic [HiSteps-1:0]    qhi_q;
  logic [ValueW-1:0]     rhi_q;

  logic [ValueW-1:0]        hi_rem, lo_rem;
  logic [HiSteps-1:0]       hi_quot;
  logic [TopQW-HiSteps-1:0] lo_quot;
  logic [TopQW-1:0]         quot;
  logic                     accept;

  assign busy   = fv_q & q_stat_i.full;
  assign accept = start & ~busy;
  assign push_o = fv_q & ~q_stat_i.full;

  // upper quotient bits straight off the input
  always_comb begin
    hi_rem  = item_i.value;
    hi_quot = '0;
    for (int j = TopQW - 1; j >= TopQW - HiSteps; j--) begin
      if (29'(hi_rem) >= (29'(radix_i.w3) << j)) begin
        hi_rem = hi_rem - 16'(29'(radix_i.w3) << j);
        hi_quot[j-(TopQW-HiSteps)] = 1'b1;
      end
    end
  end

  // lower quotient bits from the held partial remainder
  always_comb begin
    lo_rem  = rhi_q;
    lo_quot = '0;
    for (int j = TopQW - HiSteps - 1; j >= 0; j--) begin
      if (29'(lo_rem) >= (29'(radix_i.w3) << j)) begin
        lo_rem = lo_rem - 16'(29'(radix_i.w3) << j);
        lo_quot[j] = 1'b1;
      end
    end
  end

  assign quot = {qhi_q, lo_quot};

  always_comb begin
    entry_o.top_ovf   = |quot[TopQW-1:DigW];
    entry_o.top_digit = quot[DigW-1:0];
    entry_o.rem       = lo_rem[RemW-1:0];
    entry_o.shown     = {v_q >= ValueW'(radix_i.w3),
                         v_q >= ValueW'(radix_i.w2),
                         v_q >= ValueW'(radix_i.w1)};
    entry_o.points    = pts_q;
  end

  always_comb begin
    fv_d = fv_q;
    if (accept) begin
      fv_d = 1'b1;
    end else if (push_o) begin
      fv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      v_q   <= item_i.value;
      pts_q <= item_i.point_mask;
      qhi_q <= hi_quot;
      rhi_q <= hi_rem;
    end
  end

endmodule

`default_nettype wire

@@ hdl/fdse_queue.sv @@
// ---------------------------------------------------------------------------
// fdse_queue
// Two-entry queue between the classifying front and the frame back end.
// ---------------------------------------------------------------------------
`default_nettype none
`include "four_digit_seven_segment_encoder_defines.svh"

module fdse_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire fdse_pkg::q_entry_t entry_i,
  input  wire logic               pop_i,
  output fdse_pkg::q_entry_t      entry_o,
  output fdse_pkg::q_stat_t       stat_o
);
  import fdse_pkg::*;

  q_entry_t          mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign entry_o      = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  `FDSE_ASSERT_IMP(QNoOverflow, clk_i, rst_ni, push_i, !stat_o.full)
  `FDSE_ASSERT_IMP(QNoUnderflow, clk_i, rst_ni, pop_i, !stat_o.empty)
  `FDSE_ASSERT_IMP(QPtrCount, clk_i, rst_ni, stat_o.empty, wr_ptr_q == rd_ptr_q)

endmodule

`default_nettype wire

@@ hdl/fdse_back.sv @@
// ---------------------------------------------------------------------------
// fdse_back
// Pulls classified items and emits one digit frame per cycle, extracting
// each lower digit with a four-step restoring divide by its weight.
// ---------------------------------------------------------------------------
`default_nettype none
`include "four_digit_seven_segment_encoder_defines.svh"

module fdse_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fdse_pkg::radix_t   radix_i,
  input  wire logic               zero_fill_i,
  input  wire fdse_pkg::q_stat_t  q_stat_i,
  input  wire fdse_pkg::q_entry_t entry_i,
  output logic                    pop_o,
  output logic                    result_valid_o,
  output fdse_pkg::result_t       result_o
);
  import fdse_pkg::*;

  logic             act_q, act_d;
  logic [PosW-1:0]  pos_q, pos_d;
  q_entry_t         cur_q;
  logic [RemW-1:0]  rem_q, rem_d;
  logic             out_valid_q;
  result_t          out_q;

  logic [W2W-1:0]   divisor;
  logic [RemW-1:0]  r;
  logic [DigW-1:0]  d;
  logic [SegW-1:0]  fill, seg;
  result_t          frame;

  assign pop_o = ~q_stat_i.empty & (~act_q | (pos_q == PosLast));

  always_comb begin
    case (pos_q)
      2'd2:    divisor = radix_i.w2;
      2'd1:    divisor = W2W'(radix_i.w1);
      default: divisor = W2W'(1);
    endcase
  end

  always_comb begin
    r = rem_q;
    d = '0;
    for (int j = DigW - 1; j >= 0; j--) begin
      if (16'(r) >= (16'(divisor) << j)) begin
        r = r - RemW'(16'(divisor) << j);
        d[j] = 1'b1;
      end
    end
  end

  assign fill = zero_fill_i ? glyph_of('0) : '0;

  always_comb begin
    if (pos_q == PosFirst) begin
      if (!cur_q.shown[2]) begin
        seg = fill;
      end else if (cur_q.top_ovf) begin
        seg = '0;
      end else begin
        seg = glyph_of(cur_q.top_digit);
      end
    end else if (pos_q == PosLast || cur_q.shown[pos_q-1'b1]) begin
      seg = glyph_of(d);
    end else begin
      seg = fill;
    end
    frame.segments     = {seg[SegW-1:1], seg[0] | cur_q.points[pos_q]};
    frame.digit_select = ~(SelW'(1) << pos_q);
    frame.last         = (pos_q == PosLast);
  end

  always_comb begin
    act_d = act_q;
    pos_d = pos_q;
    rem_d = rem_q;
    if (pop_o) begin
      act_d = 1'b1;
      pos_d = PosFirst;
      rem_d = entry_i.rem;
    end else if (act_q) begin
      if (pos_q == PosLast) begin
        act_d = 1'b0;
      end else begin
        pos_d = pos_q - 1'b1;
        if (pos_q != PosFirst) begin
          rem_d = r;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= 1'b0;
      pos_q       <= PosFirst;
      out_valid_q <= 1'b0;
    end else begin
      act_q       <= act_d;
      pos_q       <= pos_d;
      out_valid_q <= act_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    if (pop_o) begin
      cur_q <= entry_i;
    end
    if (act_q) begin
      out_q <= frame;
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

  `FDSE_ASSERT_NXT(BkFrameRun, clk_i, rst_ni, out_valid_q && !out_q.last, out_valid_q)
  `FDSE_ASSERT_IMP(BkLastRight, clk_i, rst_ni, out_valid_q && out_q.last,
                   out_q.digit_select == ~SelW'(1))
  `FDSE_ASSERT_IMP(BkFirstLeft, clk_i, rst_ni, out_valid_q && !$past(out_valid_q),
                   out_q.digit_select == ~(SelW'(1) << PosFirst))

endmodule

`default_nettype wire

@@ hdl/four_digit_seven_segment_encoder.sv @@
// ---------------------------------------------------------------------------
// four_digit_seven_segment_encoder
// Splits a 16-bit value into four digits of a configurable radix and emits
// four segment frames, leftmost digit first, one per cycle.
// Path: front register, queue, back end item register, frame register; the
//   first frame leaves there, the other three on consecutive cycles.
// Buffering: the single frame output port sets the pace; while one value is
//   framed, three more wait in the front register and the two-entry queue.
// Reset: radix returns to 10, zero fill off, queue and frame state empty.
// ---------------------------------------------------------------------------
`default_nettype none

module four_digit_seven_segment_encoder (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire fdse_pkg::item_t                  item_i,
  output logic                                  result_valid_o,
  output fdse_pkg::result_t                     result_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [fdse_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [fdse_pkg::CfgDataW-1:0]    cfg_data_i
);
  import fdse_pkg::*;

  radix_t   radix_q;
  logic     zero_fill_q;
  q_stat_t  q_stat;
  q_entry_t push_entry, pop_entry;
  logic     push, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q     <= RadixReset;
      zero_fill_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgDigitBase: radix_q     <= radix_of(clamp_base(cfg_data_i[BaseW-1:0]));
        CfgZeroFill:  zero_fill_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  fdse_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .radix_i  (radix_q),
    .q_stat_i (q_stat),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  fdse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (pop_entry),
    .stat_o  (q_stat)
  );

  fdse_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .radix_i        (radix_q),
    .zero_fill_i    (zero_fill_q),
    .q_stat_i       (q_stat),
    .entry_i        (pop_entry),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

`default_nettype wire

@@ bench/four_digit_seven_segment_encoder_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Four digit seven segment encoder testbench
// Sends values with decimal point masks under a range of radix and zero fill
// settings, predicts the four digit frames of each value and compares every
// frame field by field as it strobes out. Covers the directed corner values
// first, then random phases with random sender gaps.
// ---------------------------------------------------------------------------

module four_digit_seven_segment_encoder_test;
  import fdse_pkg::*;

  localparam int   ClkHalf   = 2;
  localparam int   ResetLen  = 12;
  localparam int   SettleLen = 8;
  localparam int   PhaseLen  = 60;
  localparam int   Phases    = 7;
  localparam int   IdlePct   = 33;
  localparam longint LimitNs = 1_000_000;

  // indexes that map to no register
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  localparam logic [SegW-1:0] Glyph [16] = '{
    8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0,
    8'hFE, 8'hF6, 8'hEE, 8'h3E, 8'h9C, 8'h7A, 8'h9E, 8'h8E
  };

  typedef struct {
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } reg_write_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  item_t               item_i;
  logic                result_valid_o;
  result_t             result_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  four_digit_seven_segment_encoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // shadow of the block's registers
  logic [CfgDataW-1:0] radix_reg = 5'd10;
  logic                fill_reg  = 1'b0;

  result_t    frames_due[$];
  reg_write_t reg_writes[$];
  int         errors        = 0;
  int         values_sent   = 0;
  int         frames_seen   = 0;
  int         settings_seen = 1;
  bit         steady        = 1'b0;

  function automatic int clamped_radix();
    int b;
    b = radix_reg;
    if (b < 2) b = 2;
    if (b > 16) b = 16;
    return b;
  endfunction

  function automatic void predict_frames(item_t it);
    int      b, w, v, d, pos;
    result_t r;
    b = clamped_radix();
    w = b * b * b;
    v = it.value;
    for (int k = 0; k < DigitCount; k++) begin
      pos = DigitCount - 1 - k;
      if (pos == 0) begin
        d = v % b;
      end else if (v >= w) begin
        d = (k == 0) ? v / w : (v % (w * b)) / w;
      end else begin
        d = -1;
      end
      if (d < 0) begin
        r.segments = fill_reg ? Glyph[0] : '0;
      end else begin
        // an oversized top quotient has no glyph
        r.segments = (d < 16) ? Glyph[d] : '0;
      end
      r.segments[0]  = r.segments[0] | it.point_mask[pos];
      r.digit_select = ~(SelW'(1) << pos);
      r.last         = (pos == 0);
      frames_due.push_back(r);
      w = w / b;
    end
  endfunction

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && result_valid_o) begin
      frames_seen++;
      if (frames_due.size() == 0) begin
        $error("frame with no value pending: segments %h select %h last %b",
               result_o.segments, result_o.digit_select, result_o.last);
        errors++;
      end else begin
        want = frames_due.pop_front();
        if (result_o.segments !== want.segments) begin
          $error("segments: expected %h, got %h", want.segments, result_o.segments);
          errors++;
        end
        if (result_o.digit_select !== want.digit_select) begin
          $error("digit_select: expected %h, got %h",
                 want.digit_select, result_o.digit_select);
          errors++;
        end
        if (result_o.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, result_o.last);
          errors++;
        end
      end
    end
  end

  // Leaves start high after the transaction; anything that waits drops it first.
  task automatic send_value(input logic [ValueW-1:0] value,
                            input logic [PointW-1:0] points);
    item_t it;
    it.value      = value;
    it.point_mask = points;
    if (!steady && $urandom_range(99) < IdlePct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    predict_frames(it);
    values_sent++;
  endtask

  task automatic wait_frames_drained();
    start <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (SettleLen) @(posedge clk_i);
  endtask

  // Write the queued registers back to back once the block is idle.
  task automatic apply_reg_writes();
    reg_write_t wr;
    wait_frames_drained();
    while (reg_writes.size() != 0) begin
      wr = reg_writes.pop_front();
      cfg_valid_i <= 1'b1;
      cfg_index_i <= wr.idx;
      cfg_data_i  <= wr.data;
      do @(posedge clk_i); while (!cfg_ready_o);
      if (wr.idx == CfgDigitBase) radix_reg = wr.data;
      else if (wr.idx == CfgZeroFill) fill_reg = wr.data[0];
    end
    cfg_valid_i <= 1'b0;
    settings_seen++;
  endtask

  task automatic set_mode(input logic [CfgDataW-1:0] radix, input logic [CfgDataW-1:0] fill);
    reg_writes.push_back('{CfgDigitBase, radix});
    reg_writes.push_back('{CfgZeroFill, fill});
    apply_reg_writes();
  endtask

  function automatic logic [ValueW-1:0] next_value();
    int b, p, lo, v;
    b = clamped_radix();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 65535);
      4, 5, 6: begin
        p = b * b * b * b;
        v = $urandom_range(0, (p > 65536) ? 65535 : p - 1);
      end
      7: v = $urandom_range(0, b * b);
      8: begin
        p = 1;
        repeat ($urandom_range(0, 4)) p = p * b;
        v = p + $urandom_range(0, 2) - 1;
        if (v > 65535) v = 65535;
      end
      default: begin
        lo = 16 * b * b * b;
        v = (lo <= 65535) ? $urandom_range(lo, 65535) : 65535 - $urandom_range(0, 255);
      end
    endcase
    return ValueW'(v);
  endfunction

  task automatic test_reset_radix();
    send_value(16'd0, 4'h0);
    send_value(16'd65535, 4'hF);
    send_value(16'd1234, 4'h5);
    send_value(16'd9999, 4'hA);
    send_value(16'd10000, 4'h0);  // top digit ten shows as A
    send_value(16'd16000, 4'hF);  // top quotient beyond F goes blank
    send_value(16'd7, 4'h8);
  endtask

  task automatic test_hex_zero_fill();
    set_mode(5'd16, 5'b11111);
    send_value(16'hABCD, 4'h0);
    send_value(16'h0000, 4'hF);
    send_value(16'h00F0, 4'h3);
    send_value(16'hFFFF, 4'hC);
  endtask

  task automatic test_radix_clamp();
    set_mode(5'd0, 5'd0);
    send_value(16'd15, 4'h1);
    send_value(16'd65535, 4'h0);
    send_value(16'd5, 4'h2);
    set_mode(5'd1, 5'd1);
    send_value(16'd9, 4'h0);
    set_mode(5'd31, 5'd0);
    send_value(16'h1234, 4'hF);
    set_mode(5'd17, 5'd0);
    send_value(16'h0F00, 4'h0);
  endtask

  task automatic test_unknown_register();
    set_mode(5'd8, 5'd1);
    reg_writes.push_back('{CfgSpareLo, 5'd31});
    reg_writes.push_back('{CfgSpareHi, 5'd0});
    reg_writes.push_back('{CfgSpareHi, 5'd31});
    apply_reg_writes();
    send_value(16'd511, 4'h6);
    send_value(16'd4095, 4'h9);
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < Phases; ph++) begin
      case (ph)
        0: set_mode(5'd2, 5'd0);
        1: set_mode(5'd16, 5'd1);
        2: set_mode(5'd10, 5'd1);
        default: set_mode(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
      endcase
      steady = (ph == 2);
      for (int n = 0; n < PhaseLen; n++) begin
        if ($urandom_range(99) < 2) wait_frames_drained();
        send_value(next_value(), 4'($urandom_range(0, 15)));
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    item_i      <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CfgDigitBase;
    cfg_data_i  <= '0;
    repeat (ResetLen) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_radix();
    test_hex_zero_fill();
    test_radix_clamp();
    test_unknown_register();
    test_random_phases();

    wait_frames_drained();
    $display("Sent %0d values under %0d radix and fill settings; %0d frames compared.",
             values_sent, settings_seen, frames_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(LimitNs);
    $display("FAIL");
    $finish;
  end

endmodule
